@@ hw/rtl/fsmx_pkg.sv @@
// Shared constants, widths and control types of the fading sample mixer.
`default_nettype none
package fsmx_pkg;

  // Sample and register widths
  localparam int SAMPLE_BITS = 16;
  localparam int GAIN_W      = 25;
  localparam int LEVEL_W     = 17;
  localparam int CNT_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = GAIN_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_UP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DOWN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_LEVEL = 2'd2;

  // Register reset values
  localparam logic [GAIN_W-1:0]  RAMP_UP_RST   = GAIN_W'(1268);
  localparam logic [GAIN_W-1:0]  RAMP_DOWN_RST = GAIN_W'(1902);
  localparam logic [LEVEL_W-1:0] MIX_LEVEL_RST = LEVEL_W'(19661);

  // Unity gain in Q24
  localparam int GAIN_FRAC = 24;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

  // Level fraction bits, also the split point of the gain product
  localparam int LEVEL_FRAC = 16;

  // Multiplier datapath widths
  localparam int MAG_W   = SAMPLE_BITS + 1;
  localparam int P_W     = MAG_W + GAIN_W;
  localparam int PHI_W   = P_W - LEVEL_FRAC;
  localparam int MUL_A_W = (PHI_W > GAIN_W) ? PHI_W : GAIN_W;
  localparam int MUL_B_W = (MAG_W > LEVEL_W) ? MAG_W : LEVEL_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = MUL_P_W + 1;
  localparam int R_W     = SUM_W - GAIN_FRAC;
  localparam int MIX_W   = R_W + 2;

  // Saturation limits at mix width
  localparam logic signed [MIX_W-1:0] SAT_HI = MIX_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [MIX_W-1:0] SAT_LO = -SAT_HI - MIX_W'(1);

  // Stream payload widths
  localparam int IN_DATA_W  = 4 * SAMPLE_BITS;
  localparam int IN_USER_W  = 3;
  localparam int OUT_BITS   = 2 * SAMPLE_BITS + GAIN_W + CNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

  // Sequencer strobes toward the datapath
  typedef struct packed {
    logic in_ready;
    logic do_gain;
    logic mul0;
    logic mul1;
    logic mul2;
    logic do_sum;
    logic do_mix;
    logic do_fin;
    logic ch;
  } ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/fsmx_mul.sv @@
// Shared registered unsigned multiplier used by every product step.
`default_nettype none
module fsmx_mul (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [fsmx_pkg::MUL_A_W-1:0] a,
  input  wire logic [fsmx_pkg::MUL_B_W-1:0] b,
  output logic      [fsmx_pkg::MUL_P_W-1:0] prod_r
);

  // Register the product of the selected operands
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= fsmx_pkg::MUL_P_W'(a) * fsmx_pkg::MUL_P_W'(b);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/fsmx_ctrl.sv @@
// Frame sequencer: steps the shared multiplier through both channels.
`default_nettype none
module fsmx_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire logic          mixing,
  input  wire logic          out_free,
  output fsmx_pkg::ctl_t     ctl
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_GAIN = 8'b0000_0010,
    ST_MUL0 = 8'b0000_0100,
    ST_MUL1 = 8'b0000_1000,
    ST_MUL2 = 8'b0001_0000,
    ST_SUM  = 8'b0010_0000,
    ST_MIX  = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   ch_r, ch_nxt;

  // Next state and channel
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        ch_nxt    = 1'b0;
        state_nxt = mixing ? ST_MUL0 : ST_FIN;
      end
      ST_MUL0: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_MIX;
      ST_MIX: begin
        if (!ch_r) begin
          ch_nxt    = 1'b1;
          state_nxt = ST_MUL0;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  // Decode strobes
  always_comb begin
    ctl.in_ready = (state_r == ST_IDLE);
    ctl.do_gain  = (state_r == ST_GAIN);
    ctl.mul0     = (state_r == ST_MUL0);
    ctl.mul1     = (state_r == ST_MUL1);
    ctl.mul2     = (state_r == ST_MUL2);
    ctl.do_sum   = (state_r == ST_SUM);
    ctl.do_mix   = (state_r == ST_MIX);
    ctl.do_fin   = (state_r == ST_FIN) && out_free;
    ctl.ch       = ch_r;
  end

endmodule
`default_nettype wire

@@ hw/rtl/fading_sample_mixer_core.sv @@
// Top level of the fading sample mixer: ports, ramp state and mixing datapath.
//
// Usage: one stereo frame per input beat. in_tdata carries the base and effect
// samples, in_tuser the effect-present, fade-in and mix-enable flags. Each
// frame yields exactly one output beat with the saturated mixed pair, the Q24
// ramp gain after the frame and the running underflow count.
// A mixed frame passes the gain step, then per channel three products on the
// single shared multiplier, each followed by a register stage, then a sum and
// a saturating add, and last the output step; a bypassed or underflow frame
// goes from the gain step straight to the output step. The next frame is
// accepted only once the previous result is loaded into the output register.
// in_tready is high only while the sequencer is idle. The output register
// parts the two sides: a new frame is taken while a result still waits; if
// out_tready stays low the finished frame waits in the sequencer until the
// output register frees up.
// Reset (rst_n low, synchronous) clears the gain and underflow count, loads
// the register defaults and drops out_tvalid. Configuration writes through
// cfg_we/cfg_idx/cfg_wdata take effect at once and are meant for idle times.
`default_nettype none
module fading_sample_mixer_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [fsmx_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [fsmx_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // base_left, base_right, effect_left, effect_right
  input  wire logic [fsmx_pkg::IN_DATA_W-1:0]    in_tdata,
  // effect_present, fade_in, mix_enable
  input  wire logic [fsmx_pkg::IN_USER_W-1:0]    in_tuser,
  // output stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_left, out_right, gain_now, underflow_total, zero pad
  output logic [fsmx_pkg::OUT_DATA_W-1:0]        out_tdata
);

  localparam int SB = fsmx_pkg::SAMPLE_BITS;

  fsmx_pkg::ctl_t ctl;

  // Configuration registers
  logic [fsmx_pkg::GAIN_W-1:0]  up_step_r;
  logic [fsmx_pkg::GAIN_W-1:0]  down_step_r;
  logic [fsmx_pkg::LEVEL_W-1:0] level_r;

  // Ramp state
  logic [fsmx_pkg::GAIN_W-1:0] gain_r, gain_nxt;
  logic [fsmx_pkg::CNT_W-1:0]  cnt_r;

  // Latched frame
  logic signed [SB-1:0] bl_r, br_r, el_r, er_r;
  logic                 pres_r, fade_r, en_r;

  // Datapath registers
  logic [fsmx_pkg::LEVEL_FRAC-1:0] plow_r;
  logic [fsmx_pkg::MUL_P_W-1:0]    hi_r;
  logic [fsmx_pkg::R_W-1:0]        r_r;
  logic signed [SB-1:0]            res_l_r, res_r_r;

  // Output register
  logic                            out_valid_r;
  logic [fsmx_pkg::OUT_DATA_W-1:0] out_data_r;

  logic in_fire, out_free, mixing;
  logic [fsmx_pkg::MUL_P_W-1:0] prod_r;
  logic [fsmx_pkg::MUL_A_W-1:0] mul_a;
  logic [fsmx_pkg::MUL_B_W-1:0] mul_b;

  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign mixing    = en_r && pres_r;
  assign in_tready = ctl.in_ready;

  fsmx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .mixing   (mixing),
    .out_free (out_free),
    .ctl      (ctl)
  );

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_step_r   <= fsmx_pkg::RAMP_UP_RST;
      down_step_r <= fsmx_pkg::RAMP_DOWN_RST;
      level_r     <= fsmx_pkg::MIX_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        fsmx_pkg::CFG_RAMP_UP:   up_step_r   <= cfg_wdata;
        fsmx_pkg::CFG_RAMP_DOWN: down_step_r <= cfg_wdata;
        fsmx_pkg::CFG_MIX_LEVEL: level_r     <= cfg_wdata[fsmx_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Latch the accepted beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      bl_r   <= in_tdata[SB-1:0];
      br_r   <= in_tdata[2*SB-1:SB];
      el_r   <= in_tdata[3*SB-1:2*SB];
      er_r   <= in_tdata[4*SB-1:3*SB];
      pres_r <= in_tuser[0];
      fade_r <= in_tuser[1];
      en_r   <= in_tuser[2];
    end
  end

  // Step the gain toward its target and clamp there
  always_comb begin
    logic [fsmx_pkg::GAIN_W-1:0] target;
    logic [fsmx_pkg::GAIN_W-1:0] room;
    target   = fade_r ? fsmx_pkg::GAIN_ONE : '0;
    room     = '0;
    gain_nxt = target;
    if (target > gain_r) begin
      room     = target - gain_r;
      gain_nxt = (up_step_r >= room) ? target : gain_r + up_step_r;
    end else if (gain_r > target) begin
      room     = gain_r - target;
      gain_nxt = (down_step_r >= room) ? target : gain_r - down_step_r;
    end
  end

  // Update ramp state once per frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
      cnt_r  <= '0;
    end else if (ctl.do_gain && en_r) begin
      if (pres_r) gain_r <= gain_nxt;
      else        cnt_r  <= cnt_r + fsmx_pkg::CNT_W'(1);
    end
  end

  // Effect magnitude and sign of the current channel
  logic signed [SB-1:0]             eff;
  logic signed [fsmx_pkg::MAG_W-1:0] eff_ext;
  logic                             eff_neg;
  logic [fsmx_pkg::MAG_W-1:0]       mag;

  always_comb begin
    eff     = ctl.ch ? er_r : el_r;
    eff_ext = fsmx_pkg::MAG_W'(eff);
    eff_neg = eff[SB-1];
    mag     = eff_neg ? unsigned'(-eff_ext) : unsigned'(eff_ext);
  end

  // Select multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (ctl.mul0) begin
      mul_a = fsmx_pkg::MUL_A_W'(gain_r);
      mul_b = fsmx_pkg::MUL_B_W'(mag);
    end else if (ctl.mul1) begin
      mul_a = fsmx_pkg::MUL_A_W'(prod_r[fsmx_pkg::P_W-1:fsmx_pkg::LEVEL_FRAC]);
      mul_b = fsmx_pkg::MUL_B_W'(level_r);
    end else if (ctl.mul2) begin
      mul_a = fsmx_pkg::MUL_A_W'(plow_r);
      mul_b = fsmx_pkg::MUL_B_W'(level_r);
    end
  end

  fsmx_mul u_mul (
    .clk    (clk),
    .en     (ctl.mul0 || ctl.mul1 || ctl.mul2),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // Combine high and low partial products and scale down
  logic [fsmx_pkg::SUM_W-1:0] sum;
  assign sum = fsmx_pkg::SUM_W'(hi_r) + fsmx_pkg::SUM_W'(prod_r >> fsmx_pkg::LEVEL_FRAC);

  always_ff @(posedge clk) begin
    if (ctl.mul1) plow_r <= prod_r[fsmx_pkg::LEVEL_FRAC-1:0];
    if (ctl.mul2) hi_r   <= prod_r;
    if (ctl.do_sum) r_r  <= sum[fsmx_pkg::SUM_W-1:fsmx_pkg::GAIN_FRAC];
  end

  // Add the scaled effect to the base and saturate
  logic signed [fsmx_pkg::MIX_W-1:0] base_ext, delta, mix;
  logic signed [SB-1:0]              mix_sat;

  always_comb begin
    base_ext = fsmx_pkg::MIX_W'(ctl.ch ? br_r : bl_r);
    delta    = signed'(fsmx_pkg::MIX_W'(r_r));
    mix      = eff_neg ? base_ext - delta : base_ext + delta;
    if (mix > fsmx_pkg::SAT_HI)      mix_sat = SB'(fsmx_pkg::SAT_HI);
    else if (mix < fsmx_pkg::SAT_LO) mix_sat = SB'(fsmx_pkg::SAT_LO);
    else                             mix_sat = mix[SB-1:0];
  end

  // Hold the channel results; pass the base through by default
  always_ff @(posedge clk) begin
    if (ctl.do_gain) begin
      res_l_r <= bl_r;
      res_r_r <= br_r;
    end else if (ctl.do_mix) begin
      if (ctl.ch) res_r_r <= mix_sat;
      else        res_l_r <= mix_sat;
    end
  end

  // Load the output beat and drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.do_fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.do_fin) begin
      out_data_r <= {{fsmx_pkg::OUT_PAD_W{1'b0}}, cnt_r, gain_r, res_r_r, res_l_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The gain never leaves the range zero to one
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= fsmx_pkg::GAIN_ONE)
    else $error("ramp gain above unity");

  // A frame blocks the input for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input accepted while a frame is in flight");

  // A disabled frame leaves gain and counter untouched
  a_disabled_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.do_gain && !en_r) |=> ($stable(gain_r) && $stable(cnt_r)))
    else $error("ramp state changed on a disabled frame");

  // An underflow frame does not step the gain
  a_underflow_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.do_gain && en_r && !pres_r) |=> $stable(gain_r))
    else $error("gain stepped on an underflow frame");

endmodule
`default_nettype wire

@@ bench/fading_sample_mixer_core_tb.sv @@
// Self-checking testbench for the fading sample mixer: ramp, mix, saturate, underflow count.
`timescale 1ns / 1ps
module fading_sample_mixer_core_tb;
  import fsmx_pkg::*;

  localparam int HALF_PERIOD   = 2;
  localparam int IDLE_PCT      = 37;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 500000;

  // Index past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0]  CFG_SPARE    = 2'd3;
  localparam logic [CFG_DATA_W-1:0] CFG_ALL_ONES = '1;

  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] base_left;
    logic signed [SAMPLE_BITS-1:0] base_right;
    logic signed [SAMPLE_BITS-1:0] effect_left;
    logic signed [SAMPLE_BITS-1:0] effect_right;
    logic                          effect_present;
    logic                          fade_in;
    logic                          mix_enable;
  } mix_frame_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic [GAIN_W-1:0]             gain;
    logic [CNT_W-1:0]              underflows;
  } mix_result_t;

  // Ramp and mix predictor plus the queue of results still owed by the block
  class mixed_frame_checker;
    logic [GAIN_W-1:0]  up_step;
    logic [GAIN_W-1:0]  down_step;
    logic [LEVEL_W-1:0] level;
    logic [GAIN_W-1:0]  gain;
    logic [CNT_W-1:0]   underflows;
    mix_result_t        awaited_mixes[$];
    int                 failures;
    int                 beats_checked;

    function new();
      up_step       = RAMP_UP_RST;
      down_step     = RAMP_DOWN_RST;
      level         = MIX_LEVEL_RST;
      gain          = '0;
      underflows    = '0;
      failures      = 0;
      beats_checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_RAMP_UP:   up_step = val[GAIN_W-1:0];
        CFG_RAMP_DOWN: down_step = val[GAIN_W-1:0];
        CFG_MIX_LEVEL: level = val[LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    // effect * gain * level, Q40 product truncated toward zero
    function longint scaled(logic signed [SAMPLE_BITS-1:0] s);
      longint unsigned mag;
      longint unsigned prod;
      mag  = (s < 0) ? -longint'(s) : longint'(s);
      prod = (mag * gain * level) >> (GAIN_FRAC + LEVEL_FRAC);
      return (s < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function logic [SAMPLE_BITS-1:0] clip(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[SAMPLE_BITS-1:0];
    endfunction

    function void note_frame(mix_frame_t f);
      mix_result_t r;
      int unsigned target;
      int unsigned g;
      longint      mix_l;
      longint      mix_r;
      mix_l = f.base_left;
      mix_r = f.base_right;
      if (f.mix_enable) begin
        if (!f.effect_present) begin
          underflows = underflows + 1'b1;
        end else begin
          // step toward the target and clamp there
          target = f.fade_in ? int'(GAIN_ONE) : 0;
          g = gain;
          if (target > g) begin
            g = (up_step >= target - g) ? target : g + up_step;
          end else if (g > target) begin
            g = (down_step >= g - target) ? target : g - down_step;
          end else begin
            g = target;
          end
          gain  = g[GAIN_W-1:0];
          mix_l = mix_l + scaled(f.effect_left);
          mix_r = mix_r + scaled(f.effect_right);
        end
      end
      r.left       = clip(mix_l);
      r.right      = clip(mix_r);
      r.gain       = gain;
      r.underflows = underflows;
      awaited_mixes.push_back(r);
    endfunction

    function void check_beat(logic [OUT_DATA_W-1:0] d);
      mix_result_t                   exp;
      logic signed [SAMPLE_BITS-1:0] act_l;
      logic signed [SAMPLE_BITS-1:0] act_r;
      logic [GAIN_W-1:0]             act_g;
      logic [CNT_W-1:0]              act_u;
      beats_checked++;
      act_l = d[SAMPLE_BITS-1:0];
      act_r = d[2*SAMPLE_BITS-1:SAMPLE_BITS];
      act_g = d[2*SAMPLE_BITS+GAIN_W-1:2*SAMPLE_BITS];
      act_u = d[OUT_BITS-1:2*SAMPLE_BITS+GAIN_W];
      if (awaited_mixes.size() == 0) begin
        $error("result beat with no frame outstanding");
        failures++;
        return;
      end
      exp = awaited_mixes.pop_front();
      if (act_l !== exp.left) begin
        $error("out_left: expected %0d, got %0d", exp.left, act_l);
        failures++;
      end
      if (act_r !== exp.right) begin
        $error("out_right: expected %0d, got %0d", exp.right, act_r);
        failures++;
      end
      if (act_g !== exp.gain) begin
        $error("gain_now: expected %0d, got %0d", exp.gain, act_g);
        failures++;
      end
      if (act_u !== exp.underflows) begin
        $error("underflow_total: expected %0d, got %0d", exp.underflows, act_u);
        failures++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  wire                   in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  wire                   out_tvalid;
  logic                  out_tready;
  wire [OUT_DATA_W-1:0]  out_tdata;

  mixed_frame_checker frame_checker;
  mix_frame_t         seen_frame;
  int                 frames_offered  = 0;
  int                 hold_off_asked  = 0;
  int                 hold_off_served = 0;
  int unsigned        cycle_count     = 0;
  logic               tx_calm         = 1'b0;
  logic               rx_calm         = 1'b0;
  logic               fade_dir        = 1'b1;

  fading_sample_mixer_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Watch both streams; check results before noting new frames
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) frame_checker.check_beat(out_tdata);
      if (in_tvalid && in_tready) begin
        seen_frame.base_left      = in_tdata[SAMPLE_BITS-1:0];
        seen_frame.base_right     = in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        seen_frame.effect_left    = in_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
        seen_frame.effect_right   = in_tdata[4*SAMPLE_BITS-1:3*SAMPLE_BITS];
        seen_frame.effect_present = in_tuser[0];
        seen_frame.fade_in        = in_tuser[1];
        seen_frame.mix_enable     = in_tuser[2];
        frame_checker.note_frame(seen_frame);
      end
    end
  end

  // Result side: random back-pressure, calm stretches and one long hold-off
  initial begin : result_sink
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_asked > hold_off_served) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_served++;
      end else begin
        out_tready <= rx_calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic mix_frame_t frame_of(logic signed [SAMPLE_BITS-1:0] bl,
                                          logic signed [SAMPLE_BITS-1:0] br,
                                          logic signed [SAMPLE_BITS-1:0] el,
                                          logic signed [SAMPLE_BITS-1:0] er,
                                          logic present, logic fade, logic enable);
    mix_frame_t f;
    f.base_left      = bl;
    f.base_right     = br;
    f.effect_left    = el;
    f.effect_right   = er;
    f.effect_present = present;
    f.fade_in        = fade;
    f.mix_enable     = enable;
    return f;
  endfunction

  // Bias samples toward the corners
  function automatic logic signed [SAMPLE_BITS-1:0] any_sample();
    case ($urandom_range(19))
      0: return SMP_MIN;
      1: return SMP_MAX;
      2: return '0;
      3: return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Mostly mixed frames with a sticky fade direction, plus underflows and bypasses
  function automatic mix_frame_t random_frame();
    mix_frame_t f;
    int         kind;
    kind = $urandom_range(99);
    if ($urandom_range(99) < 3) fade_dir = ~fade_dir;
    f = frame_of(any_sample(), any_sample(), any_sample(), any_sample(),
                 kind < 70 || (kind >= 82 && $urandom_range(1)),
                 ($urandom_range(99) < 5) ? ~fade_dir : fade_dir,
                 kind < 82);
    return f;
  endfunction

  task automatic offer_frame(input mix_frame_t f);
    int gap;
    gap = 0;
    if (!tx_calm && $urandom_range(99) < IDLE_PCT) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {f.effect_right, f.effect_left, f.base_right, f.base_left};
    in_tuser  <= {f.mix_enable, f.fade_in, f.effect_present};
    frames_offered++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Write all registers back to back; optionally poke the unused index too
  task automatic program_regs(input logic [CFG_DATA_W-1:0] up, input logic [CFG_DATA_W-1:0] down,
                              input logic [CFG_DATA_W-1:0] level, input bit stray);
    logic [CFG_IDX_W-1:0]  idxs[4];
    logic [CFG_DATA_W-1:0] vals[4];
    int                    n;
    idxs = '{CFG_RAMP_UP, CFG_RAMP_DOWN, CFG_MIX_LEVEL, CFG_SPARE};
    vals = '{up, down, level, CFG_DATA_W'($urandom)};
    n = stray ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idxs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      frame_checker.set_reg(idxs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Drop valid and wait for every owed result
  task automatic drain();
    in_tvalid <= 1'b0;
    while (frame_checker.beats_checked < frames_offered) @(posedge clk);
  endtask

  task automatic run_frames(input int count, input int hold_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) begin
        hold_off_asked++;
        tx_calm = 1'b1;
      end
      if (hold_at >= 0 && i == hold_at + 40) tx_calm = 1'b0;
      offer_frame(random_frame());
    end
    drain();
  endtask

  initial begin : stimulus
    frame_checker = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: bypass, underflow, gain at zero, small steps, overshoot below zero
    offer_frame(frame_of(SMP_MAX, SMP_MIN, SMP_MIN, SMP_MAX, 1'b1, 1'b1, 1'b0));
    offer_frame(frame_of(SMP_MIN, SMP_MAX, SMP_MAX, SMP_MIN, 1'b0, 1'b1, 1'b1));
    offer_frame(frame_of('0, '0, SMP_MAX, SMP_MIN, 1'b1, 1'b0, 1'b1));
    offer_frame(frame_of('0, '0, SMP_MIN, SMP_MAX, 1'b1, 1'b1, 1'b1));
    offer_frame(frame_of('0, '0, SMP_MAX, SMP_MAX, 1'b1, 1'b0, 1'b1));
    offer_frame(frame_of(SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN, 1'b1, 1'b1, 1'b1));
    offer_frame(frame_of(SMP_MAX, SMP_MIN, SMP_MIN, SMP_MAX, 1'b1, 1'b1, 1'b1));
    drain();

    // Full step up, level above one (masked from all ones), stray index write
    program_regs(GAIN_W'(GAIN_ONE), CFG_DATA_W'(5000000), CFG_ALL_ONES, 1'b1);
    offer_frame(frame_of(SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN, 1'b1, 1'b1, 1'b1));
    offer_frame(frame_of(SMP_MIN, SMP_MAX, SMP_MAX, SMP_MIN, 1'b1, 1'b1, 1'b1));
    offer_frame(frame_of('0, '0, '0, '0, 1'b1, 1'b1, 1'b1));
    offer_frame(frame_of('0, '0, '1, 1, 1'b1, 1'b1, 1'b1));
    offer_frame(frame_of(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX, 1'b0, 1'b0, 1'b1));
    offer_frame(frame_of(SMP_MIN, SMP_MIN, SMP_MAX, SMP_MAX, 1'b1, 1'b0, 1'b0));
    offer_frame(frame_of(100, -100, SMP_MAX, SMP_MIN, 1'b1, 1'b0, 1'b1));
    offer_frame(frame_of(-100, 100, SMP_MIN, SMP_MAX, 1'b1, 1'b0, 1'b1));
    offer_frame(frame_of(SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN, 1'b1, 1'b0, 1'b1));
    offer_frame(frame_of(SMP_MAX, SMP_MIN, SMP_MIN, SMP_MAX, 1'b1, 1'b0, 1'b1));
    offer_frame(frame_of('1, 1, SMP_MAX, SMP_MIN, 1'b1, 1'b0, 1'b1));
    offer_frame(frame_of(SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX, 1'b1, 1'b1, 1'b1));
    offer_frame(frame_of(SMP_MAX, SMP_MIN, SMP_MIN, SMP_MAX, 1'b0, 1'b1, 1'b0));
    drain();

    // Random phases over several register settings
    program_regs(RAMP_UP_RST, RAMP_DOWN_RST, MIX_LEVEL_RST, 1'b0);
    run_frames(300, -1);

    // Instant ramps and unity level, both sides never idle
    program_regs(GAIN_W'(GAIN_ONE), CFG_ALL_ONES, CFG_DATA_W'(1 << LEVEL_FRAC), 1'b0);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    run_frames(250, -1);
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // Frozen gain, largest level
    program_regs('0, '0, CFG_ALL_ONES, 1'b1);
    run_frames(250, -1);

    program_regs(CFG_DATA_W'($urandom_range(1, 2000000)), CFG_DATA_W'($urandom_range(1, 2000000)),
                 CFG_DATA_W'($urandom), 1'b0);
    run_frames(400, -1);

    // Unit steps, level zero
    program_regs(CFG_DATA_W'(1), CFG_DATA_W'(1), '0, 1'b0);
    run_frames(200, -1);

    // Unrestricted register values; receiver holds off while the sender keeps offering
    program_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 1'b1);
    run_frames(500, 120);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (frame_checker.failures == 0 && frame_checker.awaited_mixes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
